// ===== hw/rtl/smcd_pkg.sv =====
`default_nettype none

package smcd_pkg;

    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [7:0] DIGIT_ZERO   = 8'h30;
    localparam logic [7:0] DIGIT_NINE   = 8'h39;

    localparam logic [3:0] CMD_NONE     = 4'd0;
    localparam logic [3:0] CMD_FORWARD  = 4'd1;
    localparam logic [3:0] CMD_BACKWARD = 4'd2;
    localparam logic [3:0] CMD_LEFT     = 4'd3;
    localparam logic [3:0] CMD_RIGHT    = 4'd4;
    localparam logic [3:0] CMD_STOP     = 4'd5;
    localparam logic [3:0] CMD_AUTO     = 4'd6;
    localparam logic [3:0] CMD_ROTATE   = 4'd7;
    localparam logic [3:0] CMD_BUZZER   = 4'd8;
    localparam logic [3:0] CMD_SPEED    = 4'd9;

    localparam logic [2:0] DIR_STOP     = 3'd0;
    localparam logic [2:0] DIR_FORWARD  = 3'd1;
    localparam logic [2:0] DIR_BACKWARD = 3'd2;
    localparam logic [2:0] DIR_LEFT     = 3'd3;
    localparam logic [2:0] DIR_RIGHT    = 3'd4;

    localparam logic [6:0] SPEED_MAX    = 7'd100;
    localparam logic [6:0] SPEED_RESET  = 7'd50;
    localparam logic [9:0] DUTY_MAX     = 10'd1000;
    localparam logic [4:0] DUTY_A_GAIN  = 5'd19;
    localparam logic [4:0] DUTY_B_GAIN  = 5'd15;

    localparam int NUM_WORDS        = 8;
    localparam int SPEED_PREFIX_LEN = 6;

    localparam int W_FORWARD  = 0;
    localparam int W_BACKWARD = 1;
    localparam int W_LEFT     = 2;
    localparam int W_RIGHT    = 3;
    localparam int W_STOP     = 4;
    localparam int W_AUTO     = 5;
    localparam int W_ROTATE   = 6;
    localparam int W_BUZZER   = 7;

    typedef struct packed {
        logic load_byte;
        logic walk_start;
        logic walk_step;
        logic eval;
    } ctrl_cmd_t;

    typedef struct packed {
        logic newline;
        logic line_empty;
        logic walk_last;
    } dp_status_t;

    function automatic logic [3:0] word_len(input logic [2:0] k);
        logic [3:0] len;
        case (k)
            3'd0:    len = 4'd7;
            3'd1:    len = 4'd8;
            3'd2:    len = 4'd4;
            3'd3:    len = 4'd5;
            3'd4:    len = 4'd4;
            3'd5:    len = 4'd4;
            3'd6:    len = 4'd9;
            3'd7:    len = 4'd6;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] word_char(input logic [2:0] k, input logic [3:0] i);
        logic [71:0] text;
        int          pos;
        case (k)
            3'd0:    text = 72'("forward");
            3'd1:    text = 72'("backward");
            3'd2:    text = 72'("left");
            3'd3:    text = 72'("right");
            3'd4:    text = 72'("stop");
            3'd5:    text = 72'("auto");
            3'd6:    text = 72'("rotate180");
            3'd7:    text = 72'("buzzer");
            default: text = '0;
        endcase
        pos = int'(word_len(k)) - 1 - int'(i);
        if (pos < 0) begin
            return 8'h00;
        end
        return text[8*pos +: 8];
    endfunction

    function automatic logic [7:0] prefix_char(input logic [2:0] i);
        logic [47:0] text;
        int          pos;
        text = 48'("speed:");
        pos  = SPEED_PREFIX_LEN - 1 - int'(i);
        if (pos < 0) begin
            return 8'h00;
        end
        return text[8*pos +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/smcd_rx_if.sv =====
`default_nettype none

interface smcd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/smcd_res_if.sv =====
`default_nettype none

interface smcd_res_if;
    logic       valid;
    logic       ready;
    logic       line_end;
    logic [3:0] command;
    logic       auto_mode;
    logic [2:0] direction;
    logic [6:0] speed_percent;
    logic [9:0] duty_a;
    logic [9:0] duty_b;

    modport source (
        output valid, output line_end, output command, output auto_mode,
        output direction, output speed_percent, output duty_a, output duty_b,
        input ready
    );
    modport sink (
        input valid, input line_end, input command, input auto_mode,
        input direction, input speed_percent, input duty_a, input duty_b,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/smcd_controller.sv =====
`default_nettype none

module smcd_controller import smcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    output logic       res_valid,
    input  logic       res_ready,
    output ctrl_cmd_t  cmd,
    input  dp_status_t status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (rx_valid)
                begin
                    if (!status.newline)
                    begin
                        state_next = S_OUT;
                    end
                    else if (status.line_empty)
                    begin
                        state_next = S_EVAL;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (status.walk_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: state_next = S_EVAL;
            S_EVAL:  state_next = S_OUT;
            S_OUT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign rx_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);

    assign cmd.load_byte  = (state_reg == S_IDLE) && rx_valid && !status.newline;
    assign cmd.walk_start = (state_reg == S_IDLE) && rx_valid && status.newline;
    assign cmd.walk_step  = (state_reg == S_WALK);
    assign cmd.eval       = (state_reg == S_EVAL);

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && rx_ready |=> !rx_ready)
        else $error("second word accepted while one is in flight");
    a_plain_byte_fast: assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && rx_ready && !status.newline |=> res_valid)
        else $error("plain byte result not ready next cycle");
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/smcd_datapath.sv =====
`default_nettype none

module smcd_datapath import smcd_pkg::*;
#(
    parameter int LINE_CAPACITY = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    input  logic [7:0] rx_byte,
    output logic       line_end,
    output logic [3:0] command,
    output logic       auto_mode,
    output logic [2:0] direction,
    output logic [6:0] speed_percent,
    output logic [9:0] duty_a,
    output logic [9:0] duty_b
);

    localparam int LEN_W = $clog2(LINE_CAPACITY);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_CAPACITY - 1);

    logic [7:0] line_mem [LINE_CAPACITY];

    logic [LEN_W-1:0]     len_reg;
    logic [LEN_W-1:0]     len_next;
    logic [LEN_W-1:0]     rd_idx_reg;
    logic [LEN_W-1:0]     rd_idx_next;
    logic [LEN_W-1:0]     cmp_idx_reg;
    logic                 cmp_valid_reg;
    logic [7:0]           rd_data_reg;
    logic [NUM_WORDS-1:0] word_ok_reg;
    logic [NUM_WORDS-1:0] word_ok_next;
    logic                 prefix_ok_reg;
    logic                 prefix_ok_next;
    logic                 digits_on_reg;
    logic                 digits_on_next;
    logic [6:0]           acc_reg;
    logic [6:0]           acc_next;
    logic                 mode_reg;
    logic                 mode_next;
    logic [2:0]           dir_reg;
    logic [2:0]           dir_next;
    logic [6:0]           speed_reg;
    logic [6:0]           speed_next;
    logic                 line_end_reg;
    logic                 line_end_next;
    logic [3:0]           command_reg;
    logic [3:0]           command_next;
    logic [9:0]           duty_a_reg;
    logic [9:0]           duty_a_next;
    logic [9:0]           duty_b_reg;
    logic [9:0]           duty_b_next;

    logic                 mem_wr;
    logic                 is_digit;
    logic [9:0]           acc_wide;
    logic [NUM_WORDS-1:0] word_hit;
    logic                 speed_hit;
    logic [11:0]          prod_a;
    logic [11:0]          prod_b;

    assign mem_wr = cmd.load_byte && (len_reg < LEN_LIMIT);

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            line_mem[len_reg] <= rx_byte;
        end
        rd_data_reg <= line_mem[rd_idx_reg];
    end

    assign status.newline    = (rx_byte == NEWLINE_CHAR);
    assign status.line_empty = (len_reg == '0);
    assign status.walk_last  = (rd_idx_reg == len_reg - LEN_W'(1));

    // per-byte matching against all words, the prefix and the digit run
    assign is_digit = (rd_data_reg >= DIGIT_ZERO) && (rd_data_reg <= DIGIT_NINE);
    assign acc_wide = 10'(acc_reg) * 10'd10 + 10'(rd_data_reg - DIGIT_ZERO);

    always_comb
    begin
        word_ok_next   = word_ok_reg;
        prefix_ok_next = prefix_ok_reg;
        digits_on_next = digits_on_reg;
        acc_next       = acc_reg;
        if (cmd.walk_start)
        begin
            word_ok_next   = '1;
            prefix_ok_next = 1'b1;
            digits_on_next = 1'b1;
            acc_next       = '0;
        end
        else if (cmp_valid_reg)
        begin
            for (int k = 0; k < NUM_WORDS; k++)
            begin
                if ((int'(cmp_idx_reg) < int'(word_len(3'(k)))) &&
                    (rd_data_reg != word_char(3'(k), cmp_idx_reg[3:0])))
                begin
                    word_ok_next[k] = 1'b0;
                end
            end
            if (int'(cmp_idx_reg) < SPEED_PREFIX_LEN)
            begin
                if (rd_data_reg != prefix_char(cmp_idx_reg[2:0]))
                begin
                    prefix_ok_next = 1'b0;
                end
            end
            else if (digits_on_reg)
            begin
                if (is_digit)
                begin
                    acc_next = (acc_wide > 10'(SPEED_MAX)) ? SPEED_MAX : acc_wide[6:0];
                end
                else
                begin
                    digits_on_next = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_WORDS; k++)
        begin
            word_hit[k] = word_ok_reg[k] && (int'(len_reg) == int'(word_len(3'(k))));
        end
    end

    assign speed_hit = prefix_ok_reg && (int'(len_reg) >= SPEED_PREFIX_LEN);

    always_comb
    begin
        mode_next     = mode_reg;
        dir_next      = dir_reg;
        speed_next    = speed_reg;
        line_end_next = line_end_reg;
        command_next  = command_reg;
        len_next      = len_reg;
        rd_idx_next   = rd_idx_reg;

        if (mem_wr)
        begin
            len_next = len_reg + LEN_W'(1);
        end
        if (cmd.walk_start)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.walk_step)
        begin
            rd_idx_next = rd_idx_reg + LEN_W'(1);
        end

        if (cmd.load_byte)
        begin
            line_end_next = 1'b0;
            command_next  = CMD_NONE;
        end
        else if (cmd.eval)
        begin
            line_end_next = 1'b1;
            len_next      = '0;
            if (word_hit[W_FORWARD])
            begin
                mode_next = 1'b0; dir_next = DIR_FORWARD; command_next = CMD_FORWARD;
            end
            else if (word_hit[W_BACKWARD])
            begin
                mode_next = 1'b0; dir_next = DIR_BACKWARD; command_next = CMD_BACKWARD;
            end
            else if (word_hit[W_LEFT])
            begin
                mode_next = 1'b0; dir_next = DIR_LEFT; command_next = CMD_LEFT;
            end
            else if (word_hit[W_RIGHT])
            begin
                mode_next = 1'b0; dir_next = DIR_RIGHT; command_next = CMD_RIGHT;
            end
            else if (word_hit[W_STOP])
            begin
                mode_next = 1'b0; dir_next = DIR_STOP; command_next = CMD_STOP;
            end
            else if (word_hit[W_AUTO])
            begin
                mode_next = 1'b1; dir_next = DIR_FORWARD; command_next = CMD_AUTO;
            end
            else if (word_hit[W_ROTATE])
            begin
                dir_next = DIR_FORWARD; command_next = CMD_ROTATE;
            end
            else if (word_hit[W_BUZZER])
            begin
                command_next = CMD_BUZZER;
            end
            else if (speed_hit)
            begin
                speed_next = acc_reg; command_next = CMD_SPEED;
            end
            else
            begin
                command_next = CMD_NONE;
            end
        end
    end

    assign prod_a      = 12'(speed_next) * 12'(DUTY_A_GAIN);
    assign prod_b      = 12'(speed_next) * 12'(DUTY_B_GAIN);
    assign duty_a_next = (prod_a > 12'(DUTY_MAX)) ? DUTY_MAX : prod_a[9:0];
    assign duty_b_next = (prod_b > 12'(DUTY_MAX)) ? DUTY_MAX : prod_b[9:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            mode_reg      <= 1'b1;
            dir_reg       <= DIR_STOP;
            speed_reg     <= SPEED_RESET;
        end
        else
        begin
            len_reg       <= len_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmd.walk_step;
            mode_reg      <= mode_next;
            dir_reg       <= dir_next;
            speed_reg     <= speed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= rd_idx_reg;
        word_ok_reg   <= word_ok_next;
        prefix_ok_reg <= prefix_ok_next;
        digits_on_reg <= digits_on_next;
        acc_reg       <= acc_next;
        if (cmd.load_byte || cmd.eval)
        begin
            line_end_reg <= line_end_next;
            command_reg  <= command_next;
            duty_a_reg   <= duty_a_next;
            duty_b_reg   <= duty_b_next;
        end
    end

    assign line_end      = line_end_reg;
    assign command       = command_reg;
    assign auto_mode     = mode_reg;
    assign direction     = dir_reg;
    assign speed_percent = speed_reg;
    assign duty_a        = duty_a_reg;
    assign duty_b        = duty_b_reg;

`ifndef SYNTHESIS
    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> (len_reg != '0))
        else $error("walk over an empty line");
    a_eval_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval |=> (len_reg == '0) && !cmp_valid_reg)
        else $error("line not emptied after evaluation");
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        speed_reg <= SPEED_MAX)
        else $error("speed above maximum");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/serial_motor_command_decoder.sv =====
// result: a plain byte gives its result in the cycle after it is accepted; a newline
// gives its result after the walk, drain and eval states (only eval for an empty line)
// flow: one word at a time, so no new byte or newline is taken before the result of
// the last one is taken; the line walk reads one stored byte per cycle
// and the next word is taken the cycle after the result is taken
// reset (rst_n low, async) empties the line, sets auto mode, direction stop, speed 50
`default_nettype none

module serial_motor_command_decoder import smcd_pkg::*;
#(
    parameter int LINE_CAPACITY = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    smcd_rx_if.sink     rx,
    smcd_res_if.source  res
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    smcd_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx.valid),
        .rx_ready  (rx.ready),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .cmd       (cmd),
        .status    (status)
    );

    smcd_datapath #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .rx_byte       (rx.rx_byte),
        .line_end      (res.line_end),
        .command       (res.command),
        .auto_mode     (res.auto_mode),
        .direction     (res.direction),
        .speed_percent (res.speed_percent),
        .duty_a        (res.duty_a),
        .duty_b        (res.duty_b)
    );

endmodule

`default_nettype wire
